FILE: src/pjc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pjc_pkg;

    // characters the repair logic recognizes or emits
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_L      = 8'h6C;

    // whitespace codes kept in the hold buffer
    localparam logic [1:0] WS_SPACE = 2'd0;
    localparam logic [1:0] WS_TAB   = 2'd1;
    localparam logic [1:0] WS_LF    = 2'd2;
    localparam logic [1:0] WS_CR    = 2'd3;

    // results per request are capped
    localparam int         CNT_W       = 6;
    localparam logic [5:0] MAX_RESULTS = 6'd32;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DATA_STEP,
        DP_EMIT_BSL,
        DP_EMIT_RAW,
        DP_EMIT_COMMA,
        DP_EMIT_WS,
        DP_DROP_HOLD,
        DP_EMIT_QUOTE,
        DP_EMIT_NULL,
        DP_CLOSE,
        DP_FLUSH
    } t_dp_op;

    typedef struct packed {
        logic fin;
        logic inside_str;
        logic esc_pend;
        logic comma_held;
        logic is_ws;
        logic held_full;
        logic held_empty;
        logic ws_last;
        logic null_last;
        logic stack_empty;
        logic colon;
        logic anything;
        logic emit_ok;
    } t_pjc_status;

    function automatic logic [1:0] f_ws_code(input logic [7:0] c);
        logic [1:0] code;
        code = WS_SPACE;
        case (c)
            CH_TAB:  code = WS_TAB;
            CH_LF:   code = WS_LF;
            CH_CR:   code = WS_CR;
            default: code = WS_SPACE;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] f_ws_char(input logic [1:0] code);
        logic [7:0] c;
        c = CH_SPACE;
        case (code)
            WS_TAB:  c = CH_TAB;
            WS_LF:   c = CH_LF;
            WS_CR:   c = CH_CR;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] f_null_char(input logic [1:0] idx);
        logic [7:0] c;
        c = CH_N;
        case (idx)
            2'd0:    c = CH_N;
            2'd1:    c = CH_U;
            default: c = CH_L;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/pjc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pjc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface pjc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       document_end;
    logic       depth_overflow;

    modport source (output valid, output out_byte, output last_of_run,
                    output document_end, output depth_overflow, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input document_end, input depth_overflow, output ready);
endinterface

`default_nettype wire

FILE: src/pjc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pjc_ctrl import pjc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_pjc_status i_status,
    output t_dp_op      o_dp_op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ESC,
        S_RAW,
        S_COMMA,
        S_WS,
        S_NULL,
        S_CLOSE,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        o_dp_op = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && r_ready) begin
                    o_dp_op = DP_LOAD;
                    n_state = S_DECIDE;
                    n_ready = 1'b0;
                end
            end
            S_DECIDE: begin
                if (i_status.emit_ok) begin
                    if (!i_status.fin) begin
                        if (i_status.inside_str && i_status.esc_pend) begin
                            n_state = S_ESC;
                        end else if (!i_status.inside_str && i_status.comma_held &&
                                     (!i_status.is_ws || i_status.held_full)) begin
                            n_state = S_COMMA;
                        end else begin
                            o_dp_op = DP_DATA_STEP;
                            n_state = S_FLUSH;
                        end
                    end else begin
                        // finish tail, one step per pass
                        if (i_status.comma_held && i_status.stack_empty) begin
                            n_state = S_COMMA;
                        end else if (i_status.comma_held) begin
                            o_dp_op = DP_DROP_HOLD;
                        end else if (i_status.inside_str) begin
                            o_dp_op = DP_EMIT_QUOTE;
                        end else if (!i_status.stack_empty && !i_status.colon) begin
                            n_state = S_CLOSE;
                        end else if (i_status.colon || !i_status.anything) begin
                            n_state = S_NULL;
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end
                end
            end
            S_ESC: begin
                if (i_status.emit_ok) begin
                    o_dp_op = DP_EMIT_BSL;
                    n_state = S_RAW;
                end
            end
            S_RAW: begin
                if (i_status.emit_ok) begin
                    o_dp_op = DP_EMIT_RAW;
                    n_state = S_FLUSH;
                end
            end
            S_COMMA: begin
                if (i_status.emit_ok) begin
                    o_dp_op = DP_EMIT_COMMA;
                    n_state = i_status.held_empty ? S_DECIDE : S_WS;
                end
            end
            S_WS: begin
                if (i_status.emit_ok) begin
                    o_dp_op = DP_EMIT_WS;
                    if (i_status.ws_last) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_NULL: begin
                if (i_status.emit_ok) begin
                    o_dp_op = DP_EMIT_NULL;
                    if (i_status.null_last) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_CLOSE: begin
                // the decide pass lets the registered stack read settle before another close
                if (i_status.emit_ok) begin
                    o_dp_op = DP_CLOSE;
                    n_state = S_DECIDE;
                end
            end
            S_FLUSH: begin
                if (i_status.emit_ok) begin
                    o_dp_op = DP_FLUSH;
                    n_state = S_IDLE;
                    n_ready = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_req_ready = r_ready;

endmodule

`default_nettype wire

FILE: src/pjc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pjc_datapath import pjc_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int HOLD_DEPTH  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_op      i_dp_op,
    input  logic        i_item_op,
    input  logic [7:0]  i_item_byte,
    input  logic        i_out_ready,
    output t_pjc_status o_status,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_out_end,
    output logic        o_out_ovf
);

    localparam int LW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int HCW = $clog2(HOLD_DEPTH + 1);
    localparam int HAW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int IW  = (HAW > 2) ? HAW : 2;
    localparam int CW  = (HCW > IW) ? HCW : IW;

    // item register
    logic             r_fin, n_fin;
    logic [7:0]       r_byte, n_byte;

    // parse state
    logic             r_inside, n_inside;
    logic             r_esc, n_esc;
    logic [LW-1:0]    r_level, n_level;
    logic             r_comma, n_comma;
    logic [HCW-1:0]   r_held_cnt, n_held_cnt;
    logic             r_colon, n_colon;
    logic             r_anything, n_anything;
    logic             r_ovf, n_ovf;

    // sequencing
    logic [IW-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // pending result and output register
    logic             r_pv, n_pv;
    logic [7:0]       r_pb, n_pb;
    logic             r_po, n_po;
    logic             r_ov, n_ov;
    logic [7:0]       r_ob, n_ob;
    logic             r_ol, n_ol;
    logic             r_oe, n_oe;
    logic             r_oo, n_oo;

    // container stack memory, 1 = brace
    logic             r_stack [STACK_DEPTH];
    logic             r_stk_top;
    logic             stk_we;
    logic             stk_wd;
    logic [LW-1:0]    lvl_m1;

    logic [1:0]       r_held [HOLD_DEPTH];
    logic             held_we;

    logic             is_ws;
    logic             held_full;
    logic             ws_last;
    logic             null_last;
    logic             out_free;
    logic             emit_en;
    logic [7:0]       emit_b;

    assign lvl_m1    = r_level - LW'(1);
    assign is_ws     = (r_byte == CH_SPACE) || (r_byte == CH_TAB) ||
                       (r_byte == CH_LF) || (r_byte == CH_CR);
    assign held_full = (r_held_cnt == HCW'(HOLD_DEPTH));
    assign ws_last   = ((CW'(r_idx) + CW'(1)) == CW'(r_held_cnt));
    assign null_last = (r_idx[1:0] == 2'd3);
    assign out_free  = !r_ov || i_out_ready;

    always_comb begin
        n_fin      = r_fin;
        n_byte     = r_byte;
        n_inside   = r_inside;
        n_esc      = r_esc;
        n_level    = r_level;
        n_comma    = r_comma;
        n_held_cnt = r_held_cnt;
        n_colon    = r_colon;
        n_anything = r_anything;
        n_ovf      = r_ovf;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        stk_we     = 1'b0;
        stk_wd     = (r_byte == CH_LBRACE);
        held_we    = 1'b0;
        emit_en    = 1'b0;
        emit_b     = r_byte;

        case (i_dp_op)
            DP_LOAD: begin
                n_fin  = i_item_op;
                n_byte = i_item_byte;
                n_cnt  = '0;
                n_idx  = '0;
            end
            DP_DATA_STEP: begin
                n_anything = 1'b1;
                if (r_inside) begin
                    n_colon = 1'b0;
                    if (r_byte == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        emit_en = 1'b1;
                        if (r_byte == CH_QUOTE) begin
                            n_inside = 1'b0;
                        end
                    end
                end else if (r_comma) begin
                    // whitespace that still fits behind the held comma
                    held_we    = 1'b1;
                    n_held_cnt = r_held_cnt + HCW'(1);
                end else if (r_byte == CH_COMMA) begin
                    n_comma    = 1'b1;
                    n_held_cnt = '0;
                    n_colon    = 1'b0;
                end else if (is_ws) begin
                    emit_en = 1'b1;
                end else begin
                    emit_en = 1'b1;
                    n_colon = (r_byte == CH_COLON);
                    if (r_byte == CH_QUOTE) begin
                        n_inside = 1'b1;
                    end else if (r_byte == CH_LBRACE || r_byte == CH_LBRACK) begin
                        if (r_level != LW'(STACK_DEPTH)) begin
                            stk_we  = 1'b1;
                            n_level = r_level + LW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (r_byte == CH_RBRACE || r_byte == CH_RBRACK) begin
                        if (r_level != '0 && r_stk_top == (r_byte == CH_RBRACE)) begin
                            n_level = lvl_m1;
                        end
                    end
                end
            end
            DP_EMIT_BSL: begin
                emit_en    = 1'b1;
                emit_b     = CH_BSLASH;
                n_esc      = 1'b0;
                n_anything = 1'b1;
                n_colon    = 1'b0;
            end
            DP_EMIT_RAW: begin
                emit_en = 1'b1;
            end
            DP_EMIT_COMMA: begin
                emit_en = 1'b1;
                emit_b  = CH_COMMA;
                n_idx   = '0;
                if (r_held_cnt == '0) begin
                    n_comma = 1'b0;
                end
            end
            DP_EMIT_WS: begin
                emit_en = 1'b1;
                emit_b  = f_ws_char(r_held[r_idx[HAW-1:0]]);
                if (ws_last) begin
                    n_comma    = 1'b0;
                    n_held_cnt = '0;
                    n_idx      = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            DP_DROP_HOLD: begin
                n_comma    = 1'b0;
                n_held_cnt = '0;
            end
            DP_EMIT_QUOTE: begin
                emit_en  = 1'b1;
                emit_b   = CH_QUOTE;
                n_inside = 1'b0;
                n_colon  = 1'b0;
            end
            DP_EMIT_NULL: begin
                emit_en = 1'b1;
                emit_b  = f_null_char(r_idx[1:0]);
                if (null_last) begin
                    n_colon    = 1'b0;
                    n_anything = 1'b1;
                    n_idx      = '0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            DP_CLOSE: begin
                emit_en = 1'b1;
                emit_b  = r_stk_top ? CH_RBRACE : CH_RBRACK;
                n_level = lvl_m1;
            end
            DP_FLUSH: begin
                if (r_fin) begin
                    n_inside   = 1'b0;
                    n_esc      = 1'b0;
                    n_level    = '0;
                    n_comma    = 1'b0;
                    n_held_cnt = '0;
                    n_colon    = 1'b0;
                    n_anything = 1'b0;
                    n_ovf      = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (emit_en && r_cnt != MAX_RESULTS) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    // pending stage: a result goes out only once the next one, or the end of the run, is known
    always_comb begin
        n_pv = r_pv;
        n_pb = r_pb;
        n_po = r_po;
        n_ov = out_free ? 1'b0 : r_ov;
        n_ob = r_ob;
        n_ol = r_ol;
        n_oe = r_oe;
        n_oo = r_oo;
        if (emit_en && r_cnt != MAX_RESULTS) begin
            if (r_pv) begin
                n_ov = 1'b1;
                n_ob = r_pb;
                n_ol = 1'b0;
                n_oe = 1'b0;
                n_oo = r_po;
            end
            n_pv = 1'b1;
            n_pb = emit_b;
            n_po = n_ovf;
        end
        if (i_dp_op == DP_FLUSH && r_pv) begin
            n_ov = 1'b1;
            n_ob = r_pb;
            n_ol = 1'b1;
            n_oe = r_fin;
            n_oo = r_po;
            n_pv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin      <= 1'b0;
            r_inside   <= 1'b0;
            r_esc      <= 1'b0;
            r_level    <= '0;
            r_comma    <= 1'b0;
            r_held_cnt <= '0;
            r_colon    <= 1'b0;
            r_anything <= 1'b0;
            r_ovf      <= 1'b0;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_pv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_fin      <= n_fin;
            r_inside   <= n_inside;
            r_esc      <= n_esc;
            r_level    <= n_level;
            r_comma    <= n_comma;
            r_held_cnt <= n_held_cnt;
            r_colon    <= n_colon;
            r_anything <= n_anything;
            r_ovf      <= n_ovf;
            r_idx      <= n_idx;
            r_cnt      <= n_cnt;
            r_pv       <= n_pv;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_pb   <= n_pb;
        r_po   <= n_po;
        r_ob   <= n_ob;
        r_ol   <= n_ol;
        r_oe   <= n_oe;
        r_oo   <= n_oo;
    end

    // stack top is a registered read of the entry below the level
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[r_level[SAW-1:0]] <= stk_wd;
        end
        r_stk_top <= r_stack[lvl_m1[SAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (held_we) begin
            r_held[r_held_cnt[HAW-1:0]] <= f_ws_code(r_byte);
        end
    end

    always_comb begin
        o_status.fin         = r_fin;
        o_status.inside_str  = r_inside;
        o_status.esc_pend    = r_esc;
        o_status.comma_held  = r_comma;
        o_status.is_ws       = is_ws;
        o_status.held_full   = held_full;
        o_status.held_empty  = (r_held_cnt == '0);
        o_status.ws_last     = ws_last;
        o_status.null_last   = null_last;
        o_status.stack_empty = (r_level == '0);
        o_status.colon       = r_colon;
        o_status.anything    = r_anything;
        o_status.emit_ok     = !r_pv || out_free;
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_out_last  = r_ol;
    assign o_out_end   = r_oe;
    assign o_out_ovf   = r_oo;

endmodule

`default_nettype wire

FILE: src/partial_json_closer.sv
// a request is loaded in idle; a plain data byte then passes the decide and flush states, a byte
//   after a backslash decide, escape, raw and flush; a comma release or null takes a decide pass
//   plus a step for each byte, a closer a close state, a dropped hold or closing quote a decide pass
// results pass a pending stage into the output register; an output stall holds the controller
// reset: synchronous, active low; clears parse state, stack level and output valid,
//   stack and whitespace memories keep their contents and need no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module partial_json_closer import pjc_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int HOLD_DEPTH  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pjc_in_if.sink     i_req,
    pjc_out_if.source  o_res
);

    t_pjc_status status;
    t_dp_op      dp_op;
    logic        req_ready;

    pjc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_status    (status),
        .o_dp_op     (dp_op)
    );

    pjc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .HOLD_DEPTH  (HOLD_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_op     (dp_op),
        .i_item_op   (i_req.op),
        .i_item_byte (i_req.data_byte),
        .i_out_ready (o_res.ready),
        .o_status    (status),
        .o_out_valid (o_res.valid),
        .o_out_byte  (o_res.out_byte),
        .o_out_last  (o_res.last_of_run),
        .o_out_end   (o_res.document_end),
        .o_out_ovf   (o_res.depth_overflow)
    );

    assign i_req.ready = req_ready;

endmodule

`default_nettype wire

FILE: src/pjc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pjc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_out_end,
    input logic       i_out_ovf
);

    // a request is worked on alone
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while the previous one is in progress");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_end) |-> i_out_last)
        else $error("document end without last of run");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte)))
        else $error("stalled result changed");

    // overflow stays set until the document ends
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_ovf && !i_out_end)
            |=> !(i_out_valid && !i_out_ovf))
        else $error("depth overflow cleared inside a document");

endmodule

bind partial_json_closer pjc_checker u_pjc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_byte  (o_res.out_byte),
    .i_out_last  (o_res.last_of_run),
    .i_out_end   (o_res.document_end),
    .i_out_ovf   (o_res.depth_overflow)
);

`default_nettype wire

FILE: tb/sv/partial_json_closer_tb.sv
`timescale 1ns / 1ps

module partial_json_closer_tb;
    import pjc_pkg::*;

    localparam int STACK_DEPTH   = 16;
    localparam int HOLD_DEPTH    = 8;
    localparam int RAND_ITEMS    = 250;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PRINT_LIMIT   = 40;

    localparam bit OP_DATA   = 1'b0;
    localparam bit OP_FINISH = 1'b1;

    localparam logic [7:0] WS_BYTES [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};

    typedef enum int { PH_STEADY, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       doc_end;
        logic       ovf;
    } t_out_rec;

    // text holds up to four bytes, last byte in the low end
    typedef struct packed {
        bit        op;
        bit [7:0]  data;
        bit        typed;
        bit [2:0]  n;
        bit [31:0] text;
    } t_stim_row;

    localparam t_stim_row DIRECTED [27] = '{
        '{OP_FINISH, 8'h00,     1'b1, 3'd4, "null"},
        '{OP_DATA,   8'h00,     1'b1, 3'd1, 32'h00},
        '{OP_DATA,   8'hFF,     1'b1, 3'd1, 32'hFF},
        '{OP_FINISH, 8'hFF,     1'b1, 3'd0, 32'h0},
        '{OP_DATA,   CH_LBRACE, 1'b0, 3'd0, 32'h0},
        '{OP_DATA,   CH_LBRACK, 1'b0, 3'd0, 32'h0},
        '{OP_DATA,   CH_RBRACK, 1'b0, 3'd0, 32'h0},
        // closer that does not match the top
        '{OP_DATA,   CH_RBRACK, 1'b0, 3'd0, 32'h0},
        '{OP_DATA,   CH_QUOTE,  1'b0, 3'd0, 32'h0},
        '{OP_DATA,   CH_BSLASH, 1'b1, 3'd0, 32'h0},
        '{OP_DATA,   CH_QUOTE,  1'b1, 3'd2, {16'h0, CH_BSLASH, CH_QUOTE}},
        '{OP_DATA,   CH_BSLASH, 1'b0, 3'd0, 32'h0},
        // dangling escape dropped, string and brace closed
        '{OP_FINISH, 8'h00,     1'b1, 3'd2, {16'h0, CH_QUOTE, CH_RBRACE}},
        '{OP_DATA,   CH_RBRACE, 1'b0, 3'd0, 32'h0},
        '{OP_DATA,   CH_COLON,  1'b0, 3'd0, 32'h0},
        '{OP_FINISH, 8'h00,     1'b1, 3'd4, "null"},
        '{OP_DATA,   CH_LBRACK, 1'b0, 3'd0, 32'h0},
        '{OP_DATA,   CH_COMMA,  1'b0, 3'd0, 32'h0},
        '{OP_DATA,   CH_SPACE,  1'b0, 3'd0, 32'h0},
        '{OP_DATA,   CH_CR,     1'b0, 3'd0, 32'h0},
        '{OP_FINISH, 8'h00,     1'b0, 3'd0, 32'h0},
        // top-level comma is kept with its whitespace
        '{OP_DATA,   CH_COMMA,  1'b0, 3'd0, 32'h0},
        '{OP_DATA,   CH_TAB,    1'b0, 3'd0, 32'h0},
        '{OP_FINISH, 8'h00,     1'b1, 3'd2, {16'h0, CH_COMMA, CH_TAB}},
        '{OP_DATA,   CH_LBRACE, 1'b0, 3'd0, 32'h0},
        '{OP_DATA,   CH_COLON,  1'b0, 3'd0, 32'h0},
        '{OP_FINISH, 8'h00,     1'b0, 3'd0, 32'h0}
    };

    logic clk;
    logic rst_n;

    pjc_in_if  req_if ();
    pjc_out_if res_if ();

    partial_json_closer #(
        .STACK_DEPTH (STACK_DEPTH),
        .HOLD_DEPTH  (HOLD_DEPTH)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_phase      phase;
    int          fail_count;
    int          results_checked;
    int          idle_cycles;
    t_out_rec    expected_bytes [$];
    t_stim_row   row_notes [$];
    logic [7:0]  doc_text [$];

    // repair state
    logic        in_str;
    logic        esc_pend;
    logic        comma_hold;
    logic        colon_last;
    logic        any_data;
    logic        ovf_seen;
    logic        nest_kind [STACK_DEPTH];
    int unsigned nest_level;
    logic [1:0]  hold_ws [HOLD_DEPTH];
    int unsigned hold_cnt;
    t_out_rec    step_out [$];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int ws_index(logic [7:0] c);
        case (c)
            CH_SPACE: return 0;
            CH_TAB:   return 1;
            CH_LF:    return 2;
            CH_CR:    return 3;
            default:  return -1;
        endcase
    endfunction

    function void put_byte(logic [7:0] c);
        if (step_out.size() < MAX_RESULTS) begin
            step_out.insert(step_out.size(), t_out_rec'{c, 1'b0, 1'b0, ovf_seen});
        end
    endfunction

    function void put_null();
        put_byte(CH_N);
        put_byte(CH_U);
        put_byte(CH_L);
        put_byte(CH_L);
    endfunction

    function void release_comma();
        put_byte(CH_COMMA);
        for (int i = 0; i < hold_cnt; i++) begin
            put_byte(WS_BYTES[hold_ws[i]]);
        end
        comma_hold = 1'b0;
        hold_cnt   = 0;
    endfunction

    function void clear_doc();
        in_str     = 1'b0;
        esc_pend   = 1'b0;
        nest_level = 0;
        comma_hold = 1'b0;
        hold_cnt   = 0;
        colon_last = 1'b0;
        any_data   = 1'b0;
        ovf_seen   = 1'b0;
    endfunction

    function void take_data(logic [7:0] c);
        int w;
        w = ws_index(c);
        any_data = 1'b1;
        if (in_str) begin
            colon_last = 1'b0;
            if (esc_pend) begin
                put_byte(CH_BSLASH);
                put_byte(c);
                esc_pend = 1'b0;
            end else if (c == CH_BSLASH) begin
                esc_pend = 1'b1;
            end else begin
                put_byte(c);
                if (c == CH_QUOTE) in_str = 1'b0;
            end
            return;
        end
        if (comma_hold) begin
            if (w >= 0) begin
                if (hold_cnt < HOLD_DEPTH) begin
                    hold_ws[hold_cnt] = 2'(w);
                    hold_cnt++;
                end else begin
                    release_comma();
                    put_byte(c);
                end
                return;
            end
            release_comma();
        end
        if (c == CH_COMMA) begin
            comma_hold = 1'b1;
            hold_cnt   = 0;
            colon_last = 1'b0;
            return;
        end
        if (w >= 0) begin
            put_byte(c);
            return;
        end
        colon_last = (c == CH_COLON);
        if (c == CH_QUOTE) begin
            in_str = 1'b1;
        end else if (c == CH_LBRACE || c == CH_LBRACK) begin
            if (nest_level < STACK_DEPTH) begin
                nest_kind[nest_level] = (c == CH_LBRACE);
                nest_level++;
            end else begin
                ovf_seen = 1'b1;
            end
        end else if (c == CH_RBRACE || c == CH_RBRACK) begin
            if (nest_level > 0 && nest_kind[nest_level - 1] == (c == CH_RBRACE)) begin
                nest_level--;
            end
        end
        put_byte(c);
    endfunction

    function void finish_doc();
        if (comma_hold) begin
            if (nest_level > 0) begin
                comma_hold = 1'b0;
                hold_cnt   = 0;
            end else begin
                release_comma();
            end
        end
        if (in_str) begin
            put_byte(CH_QUOTE);
            colon_last = 1'b0;
        end
        if (nest_level > 0) begin
            if (colon_last) put_null();
            while (nest_level > 0) begin
                nest_level--;
                put_byte(nest_kind[nest_level] ? CH_RBRACE : CH_RBRACK);
            end
        end else if (!any_data || colon_last) begin
            put_null();
        end
    endfunction

    function void repair_step(logic op, logic [7:0] d);
        t_out_rec tail;
        step_out.delete();
        if (op == OP_FINISH) finish_doc();
        else take_data(d);
        if (step_out.size() > 0) begin
            tail = step_out[step_out.size() - 1];
            tail.last = 1'b1;
            tail.doc_end = (op == OP_FINISH);
            step_out[step_out.size() - 1] = tail;
        end
        if (op == OP_FINISH) clear_doc();
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("mismatch in %s at result %0d: got %02h, expected %02h",
                     what, results_checked, got, want);
        end
    endtask

    // result check first, then prediction, so both orders in a step agree
    always @(posedge clk) begin
        t_out_rec  got;
        t_out_rec  want;
        t_stim_row note;
        if (rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got = t_out_rec'{res_if.out_byte, res_if.last_of_run,
                                 res_if.document_end, res_if.depth_overflow};
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected result", got.ch, 8'h00);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.ch !== want.ch) report_mismatch("out_byte", got.ch, want.ch);
                    if (got.last !== want.last) begin
                        report_mismatch("last_of_run", 8'(got.last), 8'(want.last));
                    end
                    if (got.doc_end !== want.doc_end) begin
                        report_mismatch("document_end", 8'(got.doc_end), 8'(want.doc_end));
                    end
                    if (got.ovf !== want.ovf) begin
                        report_mismatch("depth_overflow", 8'(got.ovf), 8'(want.ovf));
                    end
                end
                results_checked++;
            end
            if (req_if.valid && req_if.ready) begin
                note = row_notes.pop_front();
                repair_step(req_if.op, req_if.data_byte);
                if (note.typed) begin
                    // typed-in bytes stand in for the predicted ones
                    for (int k = 0; k < int'(note.n); k++) begin
                        expected_bytes.insert(expected_bytes.size(), t_out_rec'{
                            note.text[8 * (int'(note.n) - 1 - k) +: 8],
                            k == int'(note.n) - 1,
                            (k == int'(note.n) - 1) && (note.op == OP_FINISH),
                            1'b0});
                    end
                end else begin
                    foreach (step_out[k]) expected_bytes.insert(expected_bytes.size(), step_out[k]);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic bit src_idle();
        case (phase)
            PH_SRC_IDLE: return $urandom_range(0, 99) < 49;
            PH_BOTH:     return $urandom_range(0, 99) < 29;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit snk_stall();
        case (phase)
            PH_SNK_STALL: return $urandom_range(0, 99) < 49;
            PH_BOTH:      return $urandom_range(0, 99) < 29;
            default:      return 1'b0;
        endcase
    endfunction

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            res_if.ready <= !snk_stall();
        end
    end

    task send_item(t_stim_row row);
        row_notes.insert(row_notes.size(), row);
        while (src_idle()) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.op        <= row.op;
        req_if.data_byte <= row.data;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    function automatic void add_byte(logic [7:0] c);
        doc_text.insert(doc_text.size(), c);
    endfunction

    function automatic void add_ws(int n);
        repeat (n) add_byte(WS_BYTES[$urandom_range(0, 3)]);
    endfunction

    function automatic void add_string();
        int len;
        len = $urandom_range(0, 6);
        add_byte(CH_QUOTE);
        repeat (len) begin
            if ($urandom_range(0, 5) == 0) add_byte(CH_BSLASH);
            add_byte(8'($urandom_range(32, 126)));
        end
        add_byte(CH_QUOTE);
    endfunction

    function automatic void add_open(bit brace);
        add_byte(brace ? CH_LBRACE : CH_LBRACK);
    endfunction

    // mostly JSON-like fragments, some raw noise, sometimes cut at a random point
    function automatic void build_doc(int doc_idx);
        bit    nest [$];
        bit    brace;
        int    style;
        int    cut;
        string lit;
        doc_text.delete();
        style = (doc_idx < 2) ? doc_idx + 1 : $urandom_range(0, 9);
        if (style == 0) begin
            repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (style == 1) begin
            // nesting around the stack depth, often past it
            repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4)) begin
                brace = 1'($urandom_range(0, 1));
                add_open(brace);
                nest.insert(nest.size(), brace);
            end
        end
        if (style == 2) begin
            // whitespace run around the hold limit
            add_open(1'b0);
            nest.insert(nest.size(), 1'b0);
            add_byte(8'h31);
            add_byte(CH_COMMA);
            add_ws($urandom_range(HOLD_DEPTH - 2, HOLD_DEPTH + 3));
        end
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 9))
                0: begin
                    add_open(1'b1);
                    nest.insert(nest.size(), 1'b1);
                    add_string();
                    add_byte(CH_COLON);
                end
                1: begin
                    add_open(1'b0);
                    nest.insert(nest.size(), 1'b0);
                end
                2, 3: begin
                    if (nest.size() > 0) begin
                        add_byte(nest[nest.size() - 1] ? CH_RBRACE : CH_RBRACK);
                        nest.delete(nest.size() - 1);
                    end
                end
                4: add_string();
                5: repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(48, 57)));
                6: begin
                    add_byte(CH_COMMA);
                    if ($urandom_range(0, 4) == 0) add_ws($urandom_range(HOLD_DEPTH - 1, HOLD_DEPTH + 2));
                    else add_ws($urandom_range(0, 2));
                end
                7: add_byte(CH_COLON);
                8: add_ws($urandom_range(1, 3));
                default: begin
                    lit = "true";
                    foreach (lit[i]) add_byte(lit[i]);
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            while (nest.size() > 0) begin
                add_byte(nest[nest.size() - 1] ? CH_RBRACE : CH_RBRACK);
                nest.delete(nest.size() - 1);
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            cut = $urandom_range(0, doc_text.size());
            while (doc_text.size() > cut) doc_text.delete(doc_text.size() - 1);
        end
    endfunction

    initial begin
        t_stim_row row;
        int        sent;
        int        doc_idx;
        fail_count      = 0;
        results_checked = 0;
        idle_cycles     = 0;
        phase           = PH_STEADY;
        clear_doc();
        req_if.valid     <= 1'b0;
        req_if.op        <= OP_DATA;
        req_if.data_byte <= 8'h00;
        rst_n            <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_item(DIRECTED[i]);

        sent    = 0;
        doc_idx = 0;
        while (sent < RAND_ITEMS) begin
            phase = t_phase'((sent * 4) / RAND_ITEMS);
            build_doc(doc_idx);
            doc_idx++;
            foreach (doc_text[k]) begin
                row = '{OP_DATA, doc_text[k], 1'b0, 3'd0, 32'h0};
                send_item(row);
                sent++;
            end
            row = '{OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, 3'd0, 32'h0};
            send_item(row);
            sent++;
        end

        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: partial_json_closer.f
src/pjc_pkg.sv
src/pjc_if.sv
src/pjc_ctrl.sv
src/pjc_datapath.sv
src/partial_json_closer.sv
src/pjc_checker.sv
tb/sv/partial_json_closer_tb.sv
